[hdl/detection_median_of_five_smoother_unit_assert.svh]
// Assertion macros for the median-of-five detection smoother.
`ifndef DETECTION_MEDIAN_OF_FIVE_SMOOTHER_UNIT_ASSERT_SVH
`define DETECTION_MEDIAN_OF_FIVE_SMOOTHER_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define DMF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define DMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/dmf_pkg.sv]
// Shared types and constants for the median-of-five detection smoother.
package dmf_pkg;

  localparam int XY_W  = 11;
  localparam int RAD_W = 10;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_SEL  = 4'b0100,
    S_MRG  = 4'b1000
  } dmf_state_t;

  // Per-step strobes from the sequencer to every lane.
  typedef struct packed {
    logic shift;
    logic cmp;
    logic sel;
  } dmf_ctrl_t;

endpackage

[hdl/dmf_if.sv]
// Valid/ready channel interfaces for detection words and smoothed words.
interface dmf_in_if;
  import dmf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [XY_W-1:0]      centre_x;
  logic [XY_W-1:0]      centre_y;
  logic [RAD_W-1:0]     ball_radius;

  modport source (output valid, output found, output centre_x, output centre_y,
                  output ball_radius, input ready);
  modport sink   (input valid, input found, input centre_x, input centre_y,
                  input ball_radius, output ready);
endinterface

interface dmf_out_if;
  import dmf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [XY_W-1:0]      smooth_x;
  logic [XY_W-1:0]      smooth_y;
  logic [RAD_W-1:0]     smooth_radius;
  logic                 present;

  modport source (output valid, output smooth_x, output smooth_y,
                  output smooth_radius, output present, input ready);
  modport sink   (input valid, input smooth_x, input smooth_y,
                  input smooth_radius, input present, output ready);
endinterface

[hdl/dmf_lane.sv]
// One channel lane: sliding window, pairwise rank matrix and median pick.
module dmf_lane
  import dmf_pkg::*;
#(
  parameter int WINDOW_LEN = 5,
  parameter int WIDTH      = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dmf_ctrl_t        ctrl,
  input  logic [WIDTH-1:0] sample,
  output logic [WIDTH-1:0] median
);

  localparam int MID    = WINDOW_LEN / 2;
  localparam int RANK_W = $clog2(WINDOW_LEN) + 1;

  logic [WIDTH-1:0]      win_r     [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] below_r   [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] below_nxt [WINDOW_LEN];
  logic [WIDTH-1:0]      median_r;
  logic [WIDTH-1:0]      median_nxt;

  // Shift line, oldest entry at index zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else if (ctrl.shift) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[WINDOW_LEN-1] <= sample;
    end
  end

  // below[i][j]: entry j sorts ahead of entry i (ties broken by position).
  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      for (int j = 0; j < WINDOW_LEN; j++) begin
        below_nxt[i][j] = (j != i) &&
                          ((win_r[j] < win_r[i]) || ((win_r[j] == win_r[i]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      below_r <= below_nxt;
    end
  end

  // Ranks form a permutation, so exactly one entry sits at the middle rank.
  always_comb begin
    logic [RANK_W-1:0] rank;
    median_nxt = '0;
    rank       = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      rank = RANK_W'($countones(below_r[i]));
      if (rank == RANK_W'(MID)) begin
        median_nxt = median_nxt | win_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sel) begin
      median_r <= median_nxt;
    end
  end

  assign median = median_r;

endmodule

[hdl/dmf_merge.sv]
// Merge of the three lane medians into the registered result word.
module dmf_merge
  import dmf_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic [XY_W-1:0]  med_x,
  input  logic [XY_W-1:0]  med_y,
  input  logic [RAD_W-1:0] med_radius,
  output logic [XY_W-1:0]  smooth_x,
  output logic [XY_W-1:0]  smooth_y,
  output logic [RAD_W-1:0] smooth_radius,
  output logic             present
);

  logic [XY_W-1:0]  x_r;
  logic [XY_W-1:0]  y_r;
  logic [RAD_W-1:0] radius_r;
  logic             present_r;
  logic             hit;

  assign hit = (med_radius != '0);

  // Drop the position when the median radius says nothing was seen.
  always_ff @(posedge clk) begin
    if (load) begin
      x_r       <= hit ? med_x : '0;
      y_r       <= hit ? med_y : '0;
      radius_r  <= med_radius;
      present_r <= hit;
    end
  end

  assign smooth_x      = x_r;
  assign smooth_y      = y_r;
  assign smooth_radius = radius_r;
  assign present       = present_r;

endmodule

[hdl/detection_median_of_five_smoother_unit.sv]
// Top level of the sliding-window median smoother for ball detections.
//
// Usage:
//   in_ch carries one detection word per camera frame: found, centre_x,
//   centre_y and ball_radius. A word with found low enters the window as
//   zeros on all three channels. out_ch returns exactly one smoothed word
//   per accepted detection: the median over the last WINDOW_LEN words of
//   the column, the row and the radius, with the position zeroed and
//   present low whenever the median radius is zero.
//   Steps: the window shifts on the edge that takes the input word, then
//   the compare, select and merge states follow in that order; merge
//   holds on a receiver stall. No new word enters until merge is done;
//   the three lanes share one sequencer, which takes a word only when idle.
//   Reset (rst_n low, synchronous) empties the output register and loads
//   zeros into every window entry, so early words see those zeros.
//   Receiver stall: the result waits in the output register; the next
//   detection is still accepted and worked on, and its merge step holds
//   until the waiting word has been taken.
module detection_median_of_five_smoother_unit
  import dmf_pkg::*;
#(
  parameter int WINDOW_LEN = 5
) (
  input logic      clk,
  input logic      rst_n,
  dmf_in_if.sink   in_ch,
  dmf_out_if.source out_ch
);

  dmf_state_t       state_r;
  dmf_state_t       state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             in_take;
  logic             load;
  dmf_ctrl_t        ctrl;

  logic [XY_W-1:0]  samp_x;
  logic [XY_W-1:0]  samp_y;
  logic [RAD_W-1:0] samp_radius;
  logic [XY_W-1:0]  med_x;
  logic [XY_W-1:0]  med_y;
  logic [RAD_W-1:0] med_radius;

  // Accept a word only between items.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;

  // Merge once the output register is free or is being emptied this edge.
  assign load = (state_r == S_MRG) && (!out_valid_r || out_ch.ready);

  assign ctrl.shift = in_take;
  assign ctrl.cmp   = (state_r == S_CMP);
  assign ctrl.sel   = (state_r == S_SEL);

  // A miss pushes zeros into every window.
  assign samp_x      = in_ch.found ? in_ch.centre_x    : '0;
  assign samp_y      = in_ch.found ? in_ch.centre_y    : '0;
  assign samp_radius = in_ch.found ? in_ch.ball_radius : '0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: state_nxt = S_SEL;
      S_SEL: state_nxt = S_MRG;
      S_MRG: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // One lane per channel, all driven by the same strobes.
  dmf_lane #(.WINDOW_LEN(WINDOW_LEN), .WIDTH(XY_W)) u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .sample (samp_x),
    .median (med_x)
  );

  dmf_lane #(.WINDOW_LEN(WINDOW_LEN), .WIDTH(XY_W)) u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .sample (samp_y),
    .median (med_y)
  );

  dmf_lane #(.WINDOW_LEN(WINDOW_LEN), .WIDTH(RAD_W)) u_lane_r (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .sample (samp_radius),
    .median (med_radius)
  );

  dmf_merge u_merge (
    .clk           (clk),
    .load          (load),
    .med_x         (med_x),
    .med_y         (med_y),
    .med_radius    (med_radius),
    .smooth_x      (out_ch.smooth_x),
    .smooth_y      (out_ch.smooth_y),
    .smooth_radius (out_ch.smooth_radius),
    .present       (out_ch.present)
  );

  assign out_ch.valid = out_valid_r;

  `include "detection_median_of_five_smoother_unit_assert.svh"

  `DMF_ASSERT_ALWAYS(a_present_match, !out_ch.valid || (out_ch.present == (out_ch.smooth_radius != '0)), "present disagrees with median radius")
  `DMF_ASSERT_ALWAYS(a_miss_zero_pos, !out_ch.valid || out_ch.present || ((out_ch.smooth_x == '0) && (out_ch.smooth_y == '0)), "position not cleared on miss")
  `DMF_ASSERT_NEXT(a_one_at_a_time, in_take, !in_ch.ready, "second word taken while busy")
  `DMF_ASSERT_NEXT(a_load_shows, load, out_ch.valid, "merged word not presented")

endmodule
